FILE: sv/pedigree_inbreeding_metafounders_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands, clocked on i_clk, reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PEDIGREE_INBREEDING_METAFOUNDERS_MACROS_SVH
`define PEDIGREE_INBREEDING_METAFOUNDERS_MACROS_SVH
`ifndef ASSERT_OFF
// expression holds at every edge out of reset
`define PIM_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent at the next edge
`define PIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PIM_ASSERT_HOLDS(lbl, expr)
`define PIM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/pim_pkg.sv
// ----------------------------------------------------------------------------
// pim_pkg
// Types, constants and Q8.24 saturating helpers for the inbreeding block.
// ----------------------------------------------------------------------------
package pim_pkg;

    localparam int MAX_ANIMALS = 4096;
    localparam int MAX_MF      = 4;
    localparam int AW          = $clog2(MAX_ANIMALS);
    localparam int CW          = AW + 1;
    localparam int MW          = $clog2(MAX_MF);

    typedef logic signed [31:0] t_q;

    localparam t_q Q_ONE  = 32'sh0100_0000;
    localparam t_q Q_HALF = 32'sh0080_0000;
    localparam t_q Q_MONE = -32'sh0100_0000;

    localparam logic KIND_GAMMA  = 1'b0;
    localparam logic KIND_ANIMAL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PARENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_CHK, S_FS, S_FD, S_M2, S_M2W,
        S_PSR, S_PSW, S_PDR, S_PDW,
        S_Q1, S_Q2, S_Q3, S_Q4, S_FIN, S_DONE
    } t_state;

    function automatic t_q f_sat(input logic signed [39:0] v);
        if (v > 40'sh00_7fff_ffff)       return 32'sh7fff_ffff;
        else if (v < -40'sh00_8000_0000) return -32'sh8000_0000;
        else                             return v[31:0];
    endfunction

    function automatic t_q f_qadd(input t_q a, input t_q b);
        logic signed [39:0] s;
        s = 40'(a) + 40'(b);
        return f_sat(s);
    endfunction

    // 0.5 - (fs + fd)/4, quarter truncated toward zero
    function automatic t_q f_dterm(input t_q fs, input t_q fd);
        logic signed [39:0] s;
        logic signed [39:0] q;
        s = 40'(fs) + 40'(fd);
        q = (s < 0) ? ((s + 40'sd3) >>> 2) : (s >>> 2);
        return f_sat(40'(Q_HALF) - q);
    endfunction

endpackage

FILE: sv/pedigree_inbreeding_metafounders.sv
// ----------------------------------------------------------------------------
// pedigree_inbreeding_metafounders
// Pedigree inbreeding with metafounders, ancestor walk over stored tables.
// ----------------------------------------------------------------------------
// Requests of tuser 0 write one gamma entry; requests of tuser 1 add the
// next animal and return one result (index, F in Q8.24, status). The first
// metafounder_count animals answer gamma[k][k] - 1. Any later animal walks
// its ancestors from its own index down to 0 through the contribution
// memory: each slot is read (S_RD) and tested (S_CHK), a non-metafounder
// slot with nonzero contribution adds inbreeding reads and two multiplies
// (S_FS, S_FD, S_M2, S_M2W) plus a read-modify-write push per known parent
// (S_PSR/S_PSW, S_PDR/S_PDW) on the single contribution port. The
// metafounder quadratic form then steps S_Q1 to S_Q4 per term (nmf squared
// terms), then S_FIN. Gamma writes are taken in S_IDLE; metafounder and
// error rows go straight to S_DONE. One request is in work at a time; the
// result register lets the next request enter while a result waits. No
// clearing pass: every walk leaves the contribution memory zero again.
// ----------------------------------------------------------------------------
`include "pedigree_inbreeding_metafounders_macros.svh"

module pedigree_inbreeding_metafounders
    import pim_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,   // metafounder_count
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // mf_row[1:0] mf_col[3:2] gamma_value[35:4] sire_number[48:36]
    // dam_number[61:49], zero[63:62]
    input  logic [63:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,     // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // animal_index[11:0] inbreeding[43:12] status[45:44], zero[47:46]
    output logic [47:0] o_m_tdata
);

    // request fields
    logic [MW-1:0] w_row, w_col;
    t_q            w_gval;
    logic [CW-1:0] w_sire, w_dam;
    logic          w_kind;
    assign w_row  = i_s_tdata[1:0];
    assign w_col  = i_s_tdata[3:2];
    assign w_gval = i_s_tdata[35:4];
    assign w_sire = i_s_tdata[48:36];
    assign w_dam  = i_s_tdata[61:49];
    assign w_kind = i_s_tuser[0];

    t_state r_state, n_state;
    logic [2:0]    r_cfg;
    logic [CW-1:0] r_count;
    t_q            r_gamma [MAX_MF*MAX_MF];
    t_q            r_mfs   [MAX_MF];
    logic [AW-1:0] r_j;
    t_q            r_lj, r_ll, r_fs, r_dterm, r_acc, r_t;
    logic [CW-1:0] r_sj, r_dj;
    logic [MW-1:0] r_r, r_c;
    logic [AW-1:0] r_res_idx;
    t_q            r_res_f;
    t_status       r_res_st;
    logic          r_m_valid;
    logic [47:0]   r_m_data;

    // memories
    logic [2*CW-1:0] ped_mem [MAX_ANIMALS];
    t_q              f_mem   [MAX_ANIMALS];
    t_q              c_mem   [MAX_ANIMALS];
    logic [2*CW-1:0] ped_q;
    t_q              f_q, c_q;

    logic            ped_we;
    logic [2*CW-1:0] ped_wd;
    logic            f_we;
    t_q              f_wd;
    logic [AW-1:0]   f_ra;
    logic            c_we;
    logic [AW-1:0]   c_wa, c_ra;
    t_q              c_wd;
    t_q              mul_a, mul_b, mul_p;

    logic [2:0]    w_nmf;
    logic [AW-1:0] w_i;
    logic          w_acc, w_full, w_is_mf, w_bad, w_jmf;
    logic [CW-1:0] w_sj, w_dj;
    t_q            w_f_mf, w_f_end;
    t_state        w_nj_state;
    logic          w_out_free;

    assign w_nmf   = (r_cfg > 3'(MAX_MF)) ? 3'(MAX_MF) : r_cfg;
    assign w_i     = r_count[AW-1:0];
    assign w_acc   = i_s_tvalid && o_s_tready;
    assign w_full  = (r_count == CW'(MAX_ANIMALS));
    assign w_is_mf = (r_count < CW'(w_nmf));
    assign w_bad   = (w_sire > r_count) || (w_dam > r_count);
    assign w_jmf   = ({1'b0, r_j} < CW'(w_nmf));
    assign w_f_mf  = f_qadd(r_gamma[{w_i[MW-1:0], w_i[MW-1:0]}], Q_MONE);
    assign w_f_end = f_qadd(r_acc, Q_MONE);
    assign w_out_free = !r_m_valid || i_m_tready;

    // stored parents, guarded so a parent never follows its child
    assign w_sj = (ped_q[CW-1:0] > {1'b0, r_j}) ? '0 : ped_q[CW-1:0];
    assign w_dj = (ped_q[2*CW-1:CW] > {1'b0, r_j}) ? '0 : ped_q[2*CW-1:CW];

    // step to the next lower ancestor slot, or on to the quadratic form
    assign w_nj_state = (r_j != '0) ? S_RD : ((w_nmf == 3'd0) ? S_FIN : S_Q1);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    pim_qmul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_kind == KIND_ANIMAL) begin
                    if (w_full || w_is_mf || w_bad) n_state = S_DONE;
                    else                            n_state = S_RD;
                end
            end
            S_RD:  n_state = S_CHK;
            S_CHK: begin
                if (c_q == '0 || w_jmf) n_state = w_nj_state;
                else                    n_state = S_FS;
            end
            S_FS:  n_state = S_FD;
            S_FD:  n_state = S_M2;
            S_M2:  n_state = S_M2W;
            S_M2W: begin
                if (r_sj != '0)      n_state = S_PSR;
                else if (r_dj != '0) n_state = S_PDR;
                else                 n_state = w_nj_state;
            end
            S_PSR: n_state = S_PSW;
            S_PSW: n_state = (r_dj != '0) ? S_PDR : w_nj_state;
            S_PDR: n_state = S_PDW;
            S_PDW: n_state = w_nj_state;
            S_Q1:  n_state = S_Q2;
            S_Q2:  n_state = S_Q3;
            S_Q3:  n_state = S_Q4;
            S_Q4: begin
                if ({1'b0, r_c} == w_nmf - 3'd1 && {1'b0, r_r} == w_nmf - 3'd1)
                    n_state = S_FIN;
                else
                    n_state = S_Q1;
            end
            S_FIN:  n_state = S_DONE;
            S_DONE: n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory ports and multiplier operands
    always_comb begin
        ped_we = 1'b0;
        ped_wd = {w_dam, w_sire};
        f_we   = 1'b0;
        f_wd   = w_f_end;
        f_ra   = w_sj[AW-1:0] - AW'(1);
        c_we   = 1'b0;
        c_wa   = r_j;
        c_wd   = '0;
        c_ra   = r_j;
        mul_a  = r_ll;
        mul_b  = r_dterm;
        unique case (r_state)
            S_IDLE: begin
                c_wa = w_i;
                if (w_acc && w_kind == KIND_ANIMAL && !w_full) begin
                    if (w_is_mf) begin
                        ped_we = 1'b1;
                        ped_wd = '0;
                        f_we   = 1'b1;
                        f_wd   = w_f_mf;
                        c_we   = 1'b1;
                        c_wd   = '0;
                    end else if (!w_bad) begin
                        ped_we = 1'b1;
                        c_we   = 1'b1;
                        c_wd   = Q_ONE;
                    end
                end
            end
            S_CHK: begin
                c_we  = (c_q != '0);
                mul_a = c_q;
                mul_b = c_q;
            end
            S_FS: f_ra = r_dj[AW-1:0] - AW'(1);
            S_PSR: c_ra = r_sj[AW-1:0] - AW'(1);
            S_PSW: begin
                c_we = 1'b1;
                c_wa = r_sj[AW-1:0] - AW'(1);
                c_wd = f_qadd(c_q, r_lj >>> 1);
            end
            S_PDR: c_ra = r_dj[AW-1:0] - AW'(1);
            S_PDW: begin
                c_we = 1'b1;
                c_wa = r_dj[AW-1:0] - AW'(1);
                c_wd = f_qadd(c_q, r_lj >>> 1);
            end
            S_Q1: begin
                mul_a = r_mfs[r_r];
                mul_b = r_gamma[{r_r, r_c}];
            end
            S_Q3: begin
                mul_a = r_t;
                mul_b = r_mfs[r_c];
            end
            S_FIN: f_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ped_we) ped_mem[w_i] <= ped_wd;
        ped_q <= ped_mem[r_j];
        if (f_we) f_mem[w_i] <= f_wd;
        f_q <= f_mem[f_ra];
        if (c_we) c_mem[c_wa] <= c_wd;
        c_q <= c_mem[c_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
            for (int k = 0; k < MAX_MF*MAX_MF; k++) r_gamma[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (w_acc && w_kind == KIND_GAMMA) r_gamma[{w_row, w_col}] <= w_gval;
            if ((r_state == S_IDLE && w_acc && w_kind == KIND_ANIMAL && !w_full
                 && w_is_mf) || r_state == S_FIN)
                r_count <= r_count + CW'(1);
            if (r_state == S_DONE && w_out_free)  r_m_valid <= 1'b1;
            else if (i_m_tready)                  r_m_valid <= 1'b0;
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (n_state == S_RD && r_state != S_IDLE) r_j <= r_j - AW'(1);
        if (r_state == S_DONE && w_out_free)
            r_m_data <= {2'b00, r_res_st, r_res_f, r_res_idx};
        unique case (r_state)
            S_IDLE: begin
                r_j   <= w_i;
                r_acc <= '0;
                r_r   <= '0;
                r_c   <= '0;
                for (int k = 0; k < MAX_MF; k++) r_mfs[k] <= '0;
                r_res_idx <= w_full ? '0 : w_i;
                r_res_f   <= w_is_mf ? w_f_mf : '0;
                r_res_st  <= w_full ? ST_FULL : (w_is_mf ? ST_OK :
                             (w_bad ? ST_PARENT : ST_OK));
            end
            S_CHK: begin
                r_lj <= c_q;
                r_sj <= w_sj;
                r_dj <= w_dj;
                if (c_q != '0 && w_jmf)
                    r_mfs[r_j[MW-1:0]] <= f_qadd(r_mfs[r_j[MW-1:0]], c_q);
            end
            S_FS: begin
                r_ll <= mul_p;
                r_fs <= (r_sj == '0) ? Q_MONE : f_q;
            end
            S_FD:  r_dterm <= f_dterm(r_fs, (r_dj == '0) ? Q_MONE : f_q);
            S_M2W: r_acc <= f_qadd(r_acc, mul_p);
            S_Q2:  r_t <= mul_p;
            S_Q4: begin
                r_acc <= f_qadd(r_acc, mul_p);
                if ({1'b0, r_c} == w_nmf - 3'd1) begin
                    r_c <= '0;
                    r_r <= r_r + MW'(1);
                end else begin
                    r_c <= r_c + MW'(1);
                end
            end
            S_FIN: begin
                r_res_f  <= w_f_end;
                r_res_st <= ST_OK;
            end
            default: ;
        endcase
    end

    `PIM_ASSERT_HOLDS(a_count_range, r_count <= CW'(MAX_ANIMALS))
    `PIM_ASSERT_HOLDS(a_contrib_nonneg, !(r_state == S_CHK && c_q[31]))
    `PIM_ASSERT_NEXT(a_fin_counts, r_state == S_FIN, r_count == $past(r_count) + CW'(1))
    `PIM_ASSERT_NEXT(a_done_loads, r_state == S_DONE && w_out_free, r_m_valid)

endmodule

FILE: sv/pim_qmul.sv
// ----------------------------------------------------------------------------
// pim_qmul
// Registered Q8.24 multiplier: product truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module pim_qmul
    import pim_pkg::*;
(
    input  logic i_clk,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_p
);

    logic signed [63:0] r_prod;
    logic signed [63:0] w_adj;
    logic signed [63:0] w_sh;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    // bias negatives so the shift rounds toward zero
    assign w_adj = r_prod[63] ? (r_prod + 64'sh00ff_ffff) : r_prod;
    assign w_sh  = w_adj >>> 24;
    assign o_p   = f_sat(w_sh[39:0]);

endmodule

FILE: tb/sv/pedigree_inbreeding_metafounders_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedigree_inbreeding_metafounders_tb
// Drives gamma writes and pedigree rows into the inbreeding block, predicts
// each animal's F with an in-bench ancestor walk, and checks every result.
// ----------------------------------------------------------------------------
module pedigree_inbreeding_metafounders_tb;
    import pim_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;  // quiet cycles before giving up
    localparam int SETTLE_CYCLES  = 16;     // gamma writes give no result

    // expected result of one animal request
    typedef struct {
        logic [11:0] animal_idx;
        t_q          inbreeding;
        t_status     status;
    } t_animal_result;

    // ------------------------------------------------------------------------
    // Pedigree predictor and result checker
    // ------------------------------------------------------------------------
    class inbreeding_scoreboard;
        int             sire_tab[MAX_ANIMALS];
        int             dam_tab[MAX_ANIMALS];
        int             f_tab[MAX_ANIMALS];
        int             contrib[MAX_ANIMALS];
        int             gamma[MAX_MF*MAX_MF];
        int             mf_sum[MAX_MF];
        int             animal_count;
        int             mf_count;
        int             mismatches;
        int             results_seen;
        int             errors_seen;
        t_animal_result pending[$];

        function new();
            animal_count = 0;
            mf_count     = 0;
            mismatches   = 0;
            results_seen = 0;
            errors_seen  = 0;
            foreach (contrib[k]) contrib[k] = 0;
            foreach (gamma[k]) gamma[k] = 0;
            foreach (mf_sum[k]) mf_sum[k] = 0;
        endfunction

        function int sat(longint v);
            if (v > 64'sd2147483647) return 32'sh7fff_ffff;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return int'(v);
        endfunction

        function int qadd(int a, int b);
            return sat(longint'(a) + longint'(b));
        endfunction

        function int qmul(int a, int b);
            return sat((longint'(a) * longint'(b)) / (64'sd1 <<< 24));
        endfunction

        function int qhalf(int a);
            if (a >= 0) return a >>> 1;
            return sat(-((-longint'(a) + 1) / 2));
        endfunction

        function void set_mf_count(logic [2:0] v);
            mf_count = (v > MAX_MF) ? MAX_MF : int'(v);
        endfunction

        // predict the effect of one accepted request
        function void note_request(logic kind, logic [63:0] data);
            int             i, j, sj, dj, lj, acc, f;
            longint         fs, fd;
            int             sire, dam;
            t_animal_result r;
            sire = int'(data[48:36]);
            dam  = int'(data[61:49]);
            if (kind == KIND_GAMMA) begin
                gamma[int'(data[1:0])*MAX_MF + int'(data[3:2])] = int'(data[35:4]);
                return;
            end
            i = animal_count;
            if (i >= MAX_ANIMALS) begin
                r.animal_idx = '0;
                r.inbreeding = '0;
                r.status     = ST_FULL;
                pending.push_back(r);
                return;
            end
            r.animal_idx = i[11:0];
            r.status     = ST_OK;
            if (i < mf_count) begin
                f = qadd(gamma[i*MAX_MF + i], Q_MONE);
                sire_tab[i] = 0;
                dam_tab[i]  = 0;
            end else begin
                if (sire > i || dam > i) begin
                    r.inbreeding = '0;
                    r.status     = ST_PARENT;
                    pending.push_back(r);
                    return;
                end
                sire_tab[i] = sire;
                dam_tab[i]  = dam;
                foreach (mf_sum[k]) mf_sum[k] = 0;
                contrib[i] = Q_ONE;
                acc = 0;
                for (j = i; j >= 0; j--) begin
                    lj = contrib[j];
                    if (lj == 0) continue;
                    contrib[j] = 0;
                    if (j < mf_count) begin
                        mf_sum[j] = qadd(mf_sum[j], lj);
                        continue;
                    end
                    sj = sire_tab[j];
                    dj = dam_tab[j];
                    if (sj > j) sj = 0;
                    if (dj > j) dj = 0;
                    // unknown parent counts as F = -1
                    fs = (sj == 0) ? longint'(Q_MONE) : longint'(f_tab[sj-1]);
                    fd = (dj == 0) ? longint'(Q_MONE) : longint'(f_tab[dj-1]);
                    acc = qadd(acc, qmul(qmul(lj, lj),
                                         sat(longint'(Q_HALF) - (fs + fd) / 4)));
                    if (sj != 0) contrib[sj-1] = qadd(contrib[sj-1], qhalf(lj));
                    if (dj != 0) contrib[dj-1] = qadd(contrib[dj-1], qhalf(lj));
                end
                for (int rr = 0; rr < mf_count; rr++)
                    for (int cc = 0; cc < mf_count; cc++)
                        acc = qadd(acc, qmul(qmul(mf_sum[rr], gamma[rr*MAX_MF + cc]),
                                             mf_sum[cc]));
                f = qadd(acc, Q_MONE);
            end
            f_tab[i]     = f;
            animal_count = i + 1;
            r.inbreeding = f;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [47:0] data);
            t_animal_result w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", longint'(data), 64'sd0);
                return;
            end
            w = pending.pop_front();
            results_seen++;
            if (w.status != ST_OK) errors_seen++;
            if (data[11:0] != w.animal_idx)
                report_mismatch("animal_index", longint'(data[11:0]),
                                longint'(w.animal_idx));
            if (data[43:12] != w.inbreeding)
                report_mismatch("inbreeding", longint'(data[43:12]),
                                longint'(unsigned'(w.inbreeding)));
            if (data[45:44] != w.status)
                report_mismatch("status", longint'(data[45:44]), longint'(w.status));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;      // row, col, gamma, sire, dam, zero pad
    logic [0:0]  i_s_tuser = '0;      // kind
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;           // animal_index, inbreeding, status, pad

    always #6 i_clk = ~i_clk;

    pedigree_inbreeding_metafounders dut (.*);

    inbreeding_scoreboard sb = new();
    int send_idle_pct = 0;    // sender gap chance per request, percent
    int recv_idle_pct = 0;    // receiver stall chance per cycle, percent
    int quiet_cycles  = 0;
    int requests_sent = 0;

    // ------------------------------------------------------------------------
    // Result side: random backpressure, checking, watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d results outstanding", sb.pending.size());
                $display("FAIL pedigree_inbreeding_metafounders");
                $finish;
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Called right after a rising edge; returns at the accepting edge.
    task send_request(logic kind, logic [1:0] row, logic [1:0] col, logic [31:0] gval,
                      logic [12:0] sire, logic [12:0] dam);
        logic [63:0] d;
        d = {2'b00, dam, sire, gval, col, row};
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(kind, d);
        requests_sent++;
    endtask

    task send_gamma(logic [1:0] row, logic [1:0] col, logic [31:0] gval);
        send_request(KIND_GAMMA, row, col, gval, 13'($urandom), 13'($urandom));
    endtask

    task send_animal(logic [12:0] sire, logic [12:0] dam);
        send_request(KIND_ANIMAL, 2'($urandom), 2'($urandom), $urandom, sire, dam);
    endtask

    // drain results, let any gamma write retire, then write the register
    task set_mf_count(logic [2:0] v);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_mf_count(v);
    endtask

    // random mix: mostly valid rows, some gamma writes, a few orphans
    task random_phase(int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                // gamma mostly within +-4.0, now and then any 32-bit value
                if ($urandom_range(4) == 0)
                    send_gamma(2'($urandom), 2'($urandom), $urandom);
                else
                    send_gamma(2'($urandom), 2'($urandom),
                               $urandom_range(32'h0800_0000) - 32'h0400_0000);
            end else if (pick < 18) begin
                send_animal(13'(sb.animal_count + 1 + $urandom_range(8190 - sb.animal_count)),
                            13'($urandom_range(sb.animal_count)));
            end else begin
                send_animal(13'($urandom_range(sb.animal_count)),
                            13'($urandom_range(sb.animal_count)));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: two metafounders, extreme gammas, selfing, orphans
        set_mf_count(3'd2);
        send_gamma(2'd0, 2'd0, 32'h0180_0000);          // 1.5
        send_gamma(2'd1, 2'd1, 32'h7fff_ffff);          // max positive
        send_gamma(2'd0, 2'd1, 32'h8000_0000);          // max negative
        send_gamma(2'd1, 2'd0, 32'h0040_0000);          // 0.25
        send_gamma(2'd3, 2'd3, 32'hff00_0000);          // -1.0
        send_animal(13'd7, 13'd9);                      // metafounder: parents ignored
        send_animal(13'd0, 13'd0);                      // metafounder
        send_animal(13'd1, 13'd2);                      // offspring of both
        send_animal(13'd0, 13'd0);                      // unknown parents
        send_animal(13'd3, 13'd4);
        send_animal(13'd5, 13'd5);                      // selfing
        send_animal(13'd4096, 13'd1);                   // sire not seen
        send_animal(13'd1, 13'd8191);                   // dam not seen, all bits
        send_animal(13'd6, 13'd0);
        send_gamma(2'd0, 2'd1, 32'h0000_0000);
        send_gamma(2'd2, 2'd3, 32'h0123_4567);
        send_animal(13'd7, 13'd3);

        // sender idles lightly, receiver stalls often
        set_mf_count(3'd4);
        send_idle_pct = 12;
        recv_idle_pct = 56;
        random_phase(34);

        // sender idles more than receiver; register above the metafounder cap
        set_mf_count(3'd7);
        send_idle_pct = 56;
        recv_idle_pct = 12;
        random_phase(33);

        // back to back, no metafounders
        set_mf_count(3'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(33);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d animals stored, %0d results (%0d error rows)",
                 requests_sent, sb.animal_count, sb.results_seen, sb.errors_seen);
        $display("metafounder register swept 0, 2, 4 and 7 under three idling mixes");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS pedigree_inbreeding_metafounders");
        else
            $display("FAIL pedigree_inbreeding_metafounders");
        $finish;
    end

endmodule
